@@ hw/rtl/im3_pkg.sv @@
// ============================================================================
// im3_pkg: shared types and constants for the 3x3 matrix inverse core
// Fixed-point widths, cofactor index table and pipeline latency.
// ============================================================================
`default_nettype none

package im3_pkg;

    // matrix entry and result entry, signed q16.16
    localparam int ENT_W   = 32;
    // adjugate entry, exact 2x2 cofactor in q33.32
    localparam int ADJ_W   = 65;
    // determinant, exact q49.48
    localparam int DET_W   = 97;
    // magnitudes of the shifted numerator and of the divisor
    localparam int MAG_W   = 96;
    // quotient bits kept after the overflow check
    localparam int QUO_W   = 33;
    // number of matrix entries, one divider lane each
    localparam int LANES   = 9;
    // restoring division steps, one per pipeline stage
    localparam int STEPS   = QUO_W;
    // clock edges from accepting edge to strobe cycle
    localparam int LATENCY = 43;

    // saturation limits of the rounded quotient magnitude
    localparam logic [QUO_W:0] POS_LIM = (QUO_W+1)'(34'h07FFFFFFF);
    localparam logic [QUO_W:0] NEG_LIM = (QUO_W+1)'(34'h080000000);

    typedef logic signed [ENT_W-1:0] t_ent;
    typedef logic signed [ADJ_W-1:0] t_adj;
    typedef logic signed [DET_W-1:0] t_det;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [QUO_W-1:0]        t_quo;
    typedef logic [QUO_W:0]          t_qrnd;

    // adjugate entry k = m[a]*m[b] - m[c]*m[d], columns a b c d
    localparam logic [3:0] COF_IDX [LANES][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

`default_nettype wire

@@ hw/rtl/im3_cof.sv @@
// ============================================================================
// im3_cof: adjugate stage
// Eighteen 32x32 products registered, then nine exact cofactor differences.
// ============================================================================
`default_nettype none

module im3_cof (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire im3_pkg::t_ent i_m [im3_pkg::LANES],
    output logic              o_valid,
    output im3_pkg::t_adj     o_adj [im3_pkg::LANES],
    output im3_pkg::t_ent     o_row [3]
);

    logic                         r_vld1;
    logic                         r_vld2;
    logic signed [2*im3_pkg::ENT_W-1:0] r_pa [im3_pkg::LANES];
    logic signed [2*im3_pkg::ENT_W-1:0] r_pb [im3_pkg::LANES];
    logic signed [2*im3_pkg::ENT_W-1:0] n_pa [im3_pkg::LANES];
    logic signed [2*im3_pkg::ENT_W-1:0] n_pb [im3_pkg::LANES];
    im3_pkg::t_ent                r_row1 [3];
    im3_pkg::t_ent                r_row2 [3];
    im3_pkg::t_adj                r_adj [im3_pkg::LANES];
    im3_pkg::t_adj                n_adj [im3_pkg::LANES];

    // the two products of each cofactor
    always_comb begin
        for (int k = 0; k < im3_pkg::LANES; k++) begin
            n_pa[k] = i_m[im3_pkg::COF_IDX[k][0]] * i_m[im3_pkg::COF_IDX[k][1]];
            n_pb[k] = i_m[im3_pkg::COF_IDX[k][2]] * i_m[im3_pkg::COF_IDX[k][3]];
        end
    end

    // exact difference, one bit wider than a product
    always_comb begin
        for (int k = 0; k < im3_pkg::LANES; k++) begin
            n_adj[k] = im3_pkg::ADJ_W'(r_pa[k]) - im3_pkg::ADJ_W'(r_pb[k]);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_adj  <= n_adj;
        r_row1 <= '{i_m[0], i_m[1], i_m[2]};
        r_row2 <= r_row1;
    end

    assign o_valid = r_vld2;
    assign o_adj   = r_adj;
    assign o_row   = r_row2;

endmodule

`default_nettype wire

@@ hw/rtl/im3_det.sv @@
// ============================================================================
// im3_det: determinant stage
// First-row expansion: split partial products, term assembly, final sum.
// ============================================================================
`default_nettype none

module im3_det (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire im3_pkg::t_adj i_adj [im3_pkg::LANES],
    input  wire im3_pkg::t_ent i_row [3],
    output logic               o_valid,
    output im3_pkg::t_adj      o_adj [im3_pkg::LANES],
    output im3_pkg::t_det      o_det
);

    localparam int PP_W = im3_pkg::ENT_W + im3_pkg::ENT_W + 1;
    localparam int LO_W = im3_pkg::ENT_W;

    logic [2:0]              r_vld;
    logic signed [PP_W-1:0]  r_lo [3];
    logic signed [PP_W-1:0]  r_hi [3];
    logic signed [PP_W-1:0]  n_lo [3];
    logic signed [PP_W-1:0]  n_hi [3];
    im3_pkg::t_det           r_term [3];
    im3_pkg::t_det           n_term [3];
    im3_pkg::t_det           r_det;
    im3_pkg::t_adj           r_adj3 [im3_pkg::LANES];
    im3_pkg::t_adj           r_adj4 [im3_pkg::LANES];
    im3_pkg::t_adj           r_adj5 [im3_pkg::LANES];

    // entry times cofactor split at bit 32 of the cofactor
    always_comb begin
        logic signed [LO_W:0]                 lo_op;
        logic signed [im3_pkg::ADJ_W-LO_W-1:0] hi_op;
        for (int j = 0; j < 3; j++) begin
            lo_op   = {1'b0, i_adj[3*j][LO_W-1:0]};
            hi_op   = i_adj[3*j][im3_pkg::ADJ_W-1:LO_W];
            n_lo[j] = i_row[j] * lo_op;
            n_hi[j] = i_row[j] * hi_op;
        end
    end

    // recombine partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_term[j] = im3_pkg::DET_W'({r_hi[j], {LO_W{1'b0}}})
                      + im3_pkg::DET_W'(r_lo[j]);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_term <= n_term;
        r_det  <= r_term[0] + r_term[1] + r_term[2];
        r_adj3 <= i_adj;
        r_adj4 <= r_adj3;
        r_adj5 <= r_adj4;
    end

    assign o_valid = r_vld[2];
    assign o_adj   = r_adj5;
    assign o_det   = r_det;

endmodule

`default_nettype wire

@@ hw/rtl/im3_div.sv @@
// ============================================================================
// im3_div: nine-lane pipelined divider
// Rounded, saturated adj*2^32/det per lane, one restoring step per stage.
// ============================================================================
`default_nettype none

module im3_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire im3_pkg::t_adj i_adj [im3_pkg::LANES],
    input  wire im3_pkg::t_det i_det,
    output logic               o_valid,
    output logic               o_singular,
    output im3_pkg::t_ent      o_quo [im3_pkg::LANES],
    output logic [im3_pkg::LANES-1:0] o_sat
);

    localparam int NL   = im3_pkg::LANES;
    localparam int NS   = im3_pkg::STEPS;
    localparam int WIDE = im3_pkg::MAG_W + im3_pkg::QUO_W;
    localparam int SHN  = im3_pkg::ENT_W;

    // magnitude stage
    logic              r_a_vld;
    logic              r_a_sing;
    im3_pkg::t_mag     r_a_num [NL];
    im3_pkg::t_mag     r_a_den;
    logic [NL-1:0]     r_a_neg;
    im3_pkg::t_mag     n_a_num [NL];
    im3_pkg::t_mag     n_a_den;
    logic [NL-1:0]     n_a_neg;

    // overflow check (index 0) and restoring steps
    logic              r_vld  [NS+1];
    logic              r_sing [NS+1];
    im3_pkg::t_mag     r_den  [NS+1];
    logic [NL-1:0]     r_neg  [NS+1];
    logic [NL-1:0]     r_ovf  [NS+1];
    im3_pkg::t_mag     r_rem  [NS+1][NL];
    im3_pkg::t_quo     r_quo  [NS+1][NL];
    logic [NL-1:0]     n_ovf0;
    im3_pkg::t_mag     n_rem  [NS+1][NL];
    im3_pkg::t_quo     n_quo  [NS+1][NL];

    // rounding stage
    logic              r_c_vld;
    logic              r_c_sing;
    logic [NL-1:0]     r_c_neg;
    logic [NL-1:0]     r_c_ovf;
    im3_pkg::t_qrnd    r_c_q [NL];
    im3_pkg::t_qrnd    n_c_q [NL];

    // saturation stage
    logic              r_d_vld;
    logic              r_d_sing;
    im3_pkg::t_ent     r_d_quo [NL];
    logic [NL-1:0]     r_d_sat;
    im3_pkg::t_ent     n_d_quo [NL];
    logic [NL-1:0]     n_d_sat;

    // magnitudes, numerator pre-shifted by 32 bits into q32.64
    always_comb begin
        im3_pkg::t_adj amag;
        im3_pkg::t_det dmag;
        dmag    = i_det[im3_pkg::DET_W-1] ? -i_det : i_det;
        n_a_den = dmag[im3_pkg::MAG_W-1:0];
        for (int l = 0; l < NL; l++) begin
            amag       = i_adj[l][im3_pkg::ADJ_W-1] ? -i_adj[l] : i_adj[l];
            n_a_num[l] = {amag[im3_pkg::MAG_W-SHN-1:0], {SHN{1'b0}}};
            n_a_neg[l] = i_adj[l][im3_pkg::ADJ_W-1] ^ i_det[im3_pkg::DET_W-1];
        end
    end

    // quotient too large for the kept bits
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_ovf0[l] = ({{im3_pkg::QUO_W{1'b0}}, r_a_num[l]}
                         >= {r_a_den, {im3_pkg::QUO_W{1'b0}}});
        end
    end

    // one restoring step per stage, msb first
    always_comb begin
        logic [WIDE:0] diff;
        logic          ge;
        for (int l = 0; l < NL; l++) begin
            n_rem[0][l] = r_a_num[l];
            n_quo[0][l] = '0;
        end
        for (int s = 1; s <= NS; s++) begin
            for (int l = 0; l < NL; l++) begin
                diff = {{(im3_pkg::QUO_W+1){1'b0}}, r_rem[s-1][l]}
                     - ({{(im3_pkg::QUO_W+1){1'b0}}, r_den[s-1]} << (NS - s));
                ge   = !diff[WIDE];
                n_rem[s][l] = ge ? diff[im3_pkg::MAG_W-1:0] : r_rem[s-1][l];
                n_quo[s][l] = r_quo[s-1][l]
                            | (ge ? (im3_pkg::QUO_W'(1) << (NS - s)) : '0);
            end
        end
    end

    // round half away from zero on the magnitude
    always_comb begin
        logic up;
        for (int l = 0; l < NL; l++) begin
            up       = ({r_rem[NS][l], 1'b0} >= {1'b0, r_den[NS]});
            n_c_q[l] = {1'b0, r_quo[NS][l]} + im3_pkg::t_qrnd'(up);
        end
    end

    // clip to range and restore sign
    always_comb begin
        im3_pkg::t_qrnd lim;
        logic [im3_pkg::ENT_W-1:0] mag;
        for (int l = 0; l < NL; l++) begin
            lim        = r_c_neg[l] ? im3_pkg::NEG_LIM : im3_pkg::POS_LIM;
            n_d_sat[l] = r_c_ovf[l] || (r_c_q[l] > lim);
            mag        = n_d_sat[l] ? lim[im3_pkg::ENT_W-1:0]
                                    : r_c_q[l][im3_pkg::ENT_W-1:0];
            n_d_quo[l] = r_c_neg[l] ? -mag : mag;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            for (int s = 0; s <= NS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld  <= i_valid;
            r_vld[0] <= r_a_vld;
            for (int s = 1; s <= NS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_c_vld <= r_vld[NS];
            r_d_vld <= r_c_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_a_sing  <= (i_det == '0);
        r_a_num   <= n_a_num;
        r_a_den   <= n_a_den;
        r_a_neg   <= n_a_neg;
        r_sing[0] <= r_a_sing;
        r_den[0]  <= r_a_den;
        r_neg[0]  <= r_a_neg;
        r_ovf[0]  <= n_ovf0;
        for (int s = 1; s <= NS; s++) begin
            r_sing[s] <= r_sing[s-1];
            r_den[s]  <= r_den[s-1];
            r_neg[s]  <= r_neg[s-1];
            r_ovf[s]  <= r_ovf[s-1];
        end
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_c_sing <= r_sing[NS];
        r_c_neg  <= r_neg[NS];
        r_c_ovf  <= r_ovf[NS];
        r_c_q    <= n_c_q;
        r_d_sing <= r_c_sing;
        r_d_quo  <= n_d_quo;
        r_d_sat  <= n_d_sat;
    end

    assign o_valid    = r_d_vld;
    assign o_singular = r_d_sing;
    assign o_quo      = r_d_quo;
    assign o_sat      = r_d_sat;

endmodule

`default_nettype wire

@@ hw/rtl/invert_matrix3x3_core.sv @@
// ============================================================================
// invert_matrix3x3_core: 3x3 matrix inverse, signed q16.16
// Adjugate over determinant, rounded and saturated, singular detection.
// ============================================================================
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | start, busy       | i_m00 .. i_m22
//  result   | o_valid (strobe)  | o_inv00 .. o_inv22, o_singular, o_saturated
//
//  one matrix may enter on every clock; busy is always low
//  register stages in order: adjugate, determinant, divider set-up,
//  33 restoring division steps (one quotient bit per stage), round and
//  clip, output register
//  synchronous reset clears the valid chain only; data stages free-run
//  the receiver takes each result in its strobe cycle
//
`default_nettype none

module invert_matrix3x3_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_m00,
    input  wire logic [31:0] i_m01,
    input  wire logic [31:0] i_m02,
    input  wire logic [31:0] i_m10,
    input  wire logic [31:0] i_m11,
    input  wire logic [31:0] i_m12,
    input  wire logic [31:0] i_m20,
    input  wire logic [31:0] i_m21,
    input  wire logic [31:0] i_m22,
    output logic             o_valid,
    output logic [31:0]      o_inv00,
    output logic [31:0]      o_inv01,
    output logic [31:0]      o_inv02,
    output logic [31:0]      o_inv10,
    output logic [31:0]      o_inv11,
    output logic [31:0]      o_inv12,
    output logic [31:0]      o_inv20,
    output logic [31:0]      o_inv21,
    output logic [31:0]      o_inv22,
    output logic             o_singular,
    output logic             o_saturated
);

    im3_pkg::t_ent  mat [im3_pkg::LANES];
    logic           cof_vld;
    im3_pkg::t_adj  cof_adj [im3_pkg::LANES];
    im3_pkg::t_ent  cof_row [3];
    logic           det_vld;
    im3_pkg::t_adj  det_adj [im3_pkg::LANES];
    im3_pkg::t_det  det_val;
    logic           div_vld;
    logic           div_sing;
    im3_pkg::t_ent  div_quo [im3_pkg::LANES];
    logic [im3_pkg::LANES-1:0] div_sat;

    logic           r_valid;
    logic           r_sing;
    logic           r_sat;
    im3_pkg::t_ent  r_inv [im3_pkg::LANES];

    // no back-pressure on the input side
    assign busy = 1'b0;

    assign mat = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};

    im3_cof u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_m     (mat),
        .o_valid (cof_vld),
        .o_adj   (cof_adj),
        .o_row   (cof_row)
    );

    im3_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cof_vld),
        .i_adj   (cof_adj),
        .i_row   (cof_row),
        .o_valid (det_vld),
        .o_adj   (det_adj),
        .o_det   (det_val)
    );

    im3_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (det_vld),
        .i_adj      (det_adj),
        .i_det      (det_val),
        .o_valid    (div_vld),
        .o_singular (div_sing),
        .o_quo      (div_quo),
        .o_sat      (div_sat)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_vld;
        end
    end

    // singular matrices give zeros and no saturation
    always_ff @(posedge i_clk) begin
        r_sing <= div_sing;
        r_sat  <= !div_sing && (|div_sat);
        for (int l = 0; l < im3_pkg::LANES; l++) begin
            r_inv[l] <= div_sing ? '0 : div_quo[l];
        end
    end

    assign o_valid     = r_valid;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;
    assign o_inv00     = r_inv[0];
    assign o_inv01     = r_inv[1];
    assign o_inv02     = r_inv[2];
    assign o_inv10     = r_inv[3];
    assign o_inv11     = r_inv[4];
    assign o_inv12     = r_inv[5];
    assign o_inv20     = r_inv[6];
    assign o_inv21     = r_inv[7];
    assign o_inv22     = r_inv[8];

endmodule

`default_nettype wire

@@ hw/rtl/im3_chk.sv @@
// ============================================================================
// im3_chk: port-level checks for the 3x3 matrix inverse core
// Latency, singular result form and saturation values.
// ============================================================================
`default_nettype none

module im3_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [31:0] o_inv00,
    input wire logic [31:0] o_inv01,
    input wire logic [31:0] o_inv02,
    input wire logic [31:0] o_inv10,
    input wire logic [31:0] o_inv11,
    input wire logic [31:0] o_inv12,
    input wire logic [31:0] o_inv20,
    input wire logic [31:0] o_inv21,
    input wire logic [31:0] o_inv22,
    input wire logic        o_singular,
    input wire logic        o_saturated
);

    localparam logic [31:0] MAXV = 32'h7FFFFFFF;
    localparam logic [31:0] MINV = 32'h80000000;

    // every accepted transaction gives a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(im3_pkg::LATENCY) o_valid)
        else $error("result missing after accepted transaction");

    // no result without a transaction that caused it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, im3_pkg::LATENCY))
        else $error("result without an accepted transaction");

    // singular result is all zeros, not saturated
    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (!o_saturated
            && o_inv00 == '0 && o_inv01 == '0 && o_inv02 == '0
            && o_inv10 == '0 && o_inv11 == '0 && o_inv12 == '0
            && o_inv20 == '0 && o_inv21 == '0 && o_inv22 == '0))
        else $error("singular result not cleared");

    // saturation leaves at least one entry at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_inv00 == MAXV || o_inv00 == MINV || o_inv01 == MAXV || o_inv01 == MINV
          || o_inv02 == MAXV || o_inv02 == MINV || o_inv10 == MAXV || o_inv10 == MINV
          || o_inv11 == MAXV || o_inv11 == MINV || o_inv12 == MAXV || o_inv12 == MINV
          || o_inv20 == MAXV || o_inv20 == MINV || o_inv21 == MAXV || o_inv21 == MINV
          || o_inv22 == MAXV || o_inv22 == MINV))
        else $error("saturation flagged with no entry at a limit");

endmodule

bind invert_matrix3x3_core im3_chk u_im3_chk (.*);

`default_nettype wire
